### rtl/dbpskm_pkg.sv
// shared constants and types for the dbpsk carrier modulator
`timescale 1ns / 1ps

package dbpskm_pkg;

   // width of the configuration write data, set by the widest register
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_INDEX_BITS = 2;

   // configuration register indexes
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PHASE_STEP     = 2'd0,
      CSR_CYCLES_PER_BIT = 2'd1,
      CSR_TRAINING_BITS  = 2'd2,
      CSR_FRAME_SAMPLES  = 2'd3
   } csr_index_type;

   // register reset values
   localparam logic [31:0] PHASE_STEP_RESET     = 32'h1000_0000;
   localparam logic [7:0]  CYCLES_PER_BIT_RESET = 8'd4;
   localparam logic [15:0] TRAINING_BITS_RESET  = 16'd8;
   localparam logic [31:0] FRAME_SAMPLES_RESET  = 32'd0;

   // pi/2 in unsigned q30
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   // taylor series divisors (2k)(2k+1) for k = 1..7
   localparam longint unsigned TAYLOR_DIV [7] = '{
      64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210
   };

   // saturation value of the training counter
   localparam logic [15:0] TRAIN_COUNT_MAX = 16'hFFFF;

endpackage

### rtl/dbpskm_if.sv
// request and result channel interfaces of the dbpsk carrier modulator
`timescale 1ns / 1ps

// request channel: one sample tick
interface dbpskm_req_if;
   logic valid;
   logic ready;
   logic start_frame;
   logic data_bit;

   modport source (output valid, output start_frame, output data_bit, input ready);
   modport sink   (input valid, input start_frame, input data_bit, output ready);
endinterface

// result channel: one carrier sample and its flags
interface dbpskm_rsp_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          bit_taken;
   logic                          in_training;
   logic                          frame_active;

   modport source (
      output valid, output sample, output bit_taken, output in_training,
      output frame_active, input ready
   );
   modport sink (
      input valid, input sample, input bit_taken, input in_training,
      input frame_active, output ready
   );
endinterface

### rtl/dbpskm_sine.sv
// quarter-wave sine table folded by quadrant, with sign control
`timescale 1ns / 1ps

module dbpskm_sine
   import dbpskm_pkg::*;
#(
   parameter int SINE_TABLE_BITS = 10,
   parameter int SAMPLE_BITS     = 16
) (
   input  logic [SINE_TABLE_BITS-1:0]  idx,
   input  logic                        negate,
   output logic signed [SAMPLE_BITS-1:0] sample
);

   localparam int QBITS = SINE_TABLE_BITS - 2;
   localparam int QSIZE = (1 << QBITS) + 1;
   localparam longint unsigned AMP = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;

   typedef logic [SAMPLE_BITS-2:0] qtr_type [QSIZE];

   // quarter-wave table, entry j = round(sin((pi/2)*j/q) * amp) via q30 taylor series
   function automatic qtr_type build_qtr();
      qtr_type         tbl;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned sum;
      longint unsigned v;
      for (int j = 0; j < QSIZE; j++) begin
         x = (HALF_PI_Q30 * longint'(j)) >> QBITS;
         x2 = (x * x) >> 30;
         term = x;
         sum = x;
         for (int k = 1; k <= 7; k++) begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[k-1];
            if (k[0]) begin
               sum = (sum >= term) ? sum - term : 64'd0;
            end else begin
               sum = sum + term;
            end
         end
         v = (sum * AMP + (64'd1 << 29)) >> 30;
         if (v > AMP) begin
            v = AMP;
         end
         tbl[j] = v[SAMPLE_BITS-2:0];
      end
      return tbl;
   endfunction

   localparam qtr_type QTR = build_qtr();
   localparam logic [QBITS:0] QTR_TOP = (QBITS+1)'(1 << QBITS);

   logic [1:0]             quad;
   logic [QBITS-1:0]       step_in_quad;
   logic [QBITS:0]         addr;
   logic [SAMPLE_BITS-1:0] mag;

   // fold the index onto the first quadrant
   always_comb begin
      quad         = idx[SINE_TABLE_BITS-1 -: 2];
      step_in_quad = idx[QBITS-1:0];
      addr         = quad[0] ? (QTR_TOP - {1'b0, step_in_quad}) : {1'b0, step_in_quad};
      mag          = {1'b0, QTR[addr]};
      sample       = (negate ^ quad[1]) ? -mag : mag;
   end

endmodule

### rtl/dbpsk_carrier_modulator_top.sv
// Differential BPSK carrier modulator: one signed carrier sample per request.
// Each accepted request advances a fixed point phase accumulator (8 integer
// bits of carrier cycles plus PHASE_FRAC_BITS fraction bits) and yields one
// sample of sin(2*pi*phase), negated while the differential inversion is set.
// It accepts one request every clock cycle unless the output stalls; results
// pass the stage one and output registers, and a full output register with the
// consumer stalled holds back at most one further request. The rate is set by
// the phase update loop, a 40 bit compare, subtract and add into the phase
// register; the later stage looks up the sine in a constant quarter-wave table.
// Configuration registers are written through csr_wen/csr_index/csr_wdata and
// must only change while no request is in flight. No clearing pass is needed
// after reset.
`timescale 1ns / 1ps

module dbpsk_carrier_modulator_top
   import dbpskm_pkg::*;
#(
   parameter int PHASE_FRAC_BITS = 32,
   parameter int SINE_TABLE_BITS = 10,
   parameter int SAMPLE_BITS     = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wen,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   dbpskm_req_if.sink                req_ch,
   dbpskm_rsp_if.source              rsp_ch
);

   localparam int PHASE_BITS = PHASE_FRAC_BITS + 8;
   localparam int STEP_LSH   = (PHASE_FRAC_BITS >= 32) ? PHASE_FRAC_BITS - 32 : 0;
   localparam int STEP_RSH   = (PHASE_FRAC_BITS < 32) ? 32 - PHASE_FRAC_BITS : 0;
   localparam int WIDE_BITS  = PHASE_BITS + 32;

   // configuration registers
   logic [31:0] phase_step_ff;
   logic [7:0]  cycles_per_bit_ff;
   logic [15:0] training_bits_ff;
   logic [31:0] frame_samples_ff;

   // modulator state
   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic                  invert_ff, invert_in;
   logic                  training_ff, training_in;
   logic [15:0]           train_count_ff, train_count_in;
   logic [31:0]           sample_count_ff, sample_count_in;

   // stage one registers
   logic                       s1_valid_ff, s1_valid_in;
   logic [SINE_TABLE_BITS-1:0] s1_idx_ff;
   logic                       s1_neg_ff;
   logic                       s1_taken_ff;
   logic                       s1_train_ff;
   logic                       s1_active_ff;

   // output registers
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff;
   logic                          rsp_taken_ff;
   logic                          rsp_train_ff;
   logic                          rsp_active_ff;

   logic                          s2_adv;
   logic                          accept;
   logic [PHASE_BITS-1:0]         threshold;
   logic [PHASE_BITS-1:0]         phase_red;
   logic [PHASE_BITS-1:0]         step_scaled;
   logic [WIDE_BITS-1:0]          step_wide;
   logic                          boundary;
   logic                          active;
   logic                          taken;
   logic                          invert_cur;
   logic                          training_cur;
   logic [15:0]                   train_count_cur;
   logic [31:0]                   sample_count_cur;
   logic signed [SAMPLE_BITS-1:0] sine_sample;

   // handshake
   assign s2_adv       = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !s1_valid_ff || s2_adv;
   assign accept       = req_ch.valid && req_ch.ready;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff     <= PHASE_STEP_RESET;
         cycles_per_bit_ff <= CYCLES_PER_BIT_RESET;
         training_bits_ff  <= TRAINING_BITS_RESET;
         frame_samples_ff  <= FRAME_SAMPLES_RESET;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_PHASE_STEP:     phase_step_ff     <= csr_wdata;
            CSR_CYCLES_PER_BIT: cycles_per_bit_ff <= csr_wdata[7:0];
            CSR_TRAINING_BITS:  training_bits_ff  <= csr_wdata[15:0];
            CSR_FRAME_SAMPLES:  frame_samples_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // phase step aligned to the accumulator fraction
   always_comb begin
      step_wide   = ({(PHASE_BITS)'(0), phase_step_ff} << STEP_LSH) >> STEP_RSH;
      step_scaled = step_wide[PHASE_BITS-1:0];
      threshold   = {cycles_per_bit_ff, (PHASE_FRAC_BITS)'(0)};
   end

   // per request state update: frame start, bit boundary, phase advance
   always_comb begin
      invert_cur       = req_ch.start_frame ? 1'b0 : invert_ff;
      training_cur     = req_ch.start_frame ? 1'b1 : training_ff;
      train_count_cur  = req_ch.start_frame ? 16'd1 : train_count_ff;
      sample_count_cur = req_ch.start_frame ? 32'd1 : sample_count_ff;

      active    = sample_count_cur < frame_samples_ff;
      boundary  = phase_ff > threshold;
      phase_red = boundary ? phase_ff - threshold : phase_ff;

      invert_in      = invert_cur;
      training_in    = training_cur;
      train_count_in = train_count_cur;
      taken          = 1'b0;
      if (boundary && active) begin
         if (train_count_cur >= training_bits_ff) begin
            training_in = 1'b0;
         end
         if (training_in) begin
            if (train_count_cur != TRAIN_COUNT_MAX) begin
               train_count_in = train_count_cur + 16'd1;
            end
         end else begin
            taken     = 1'b1;
            invert_in = invert_cur ^ req_ch.data_bit;
         end
      end

      phase_in        = phase_red + step_scaled;
      sample_count_in = active ? sample_count_cur + 32'd1 : sample_count_cur;
   end

   // modulator state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= '0;
         invert_ff       <= 1'b0;
         training_ff     <= 1'b1;
         train_count_ff  <= 16'd1;
         sample_count_ff <= 32'd1;
      end else if (accept) begin
         phase_ff        <= phase_in;
         invert_ff       <= invert_in;
         training_ff     <= training_in;
         train_count_ff  <= train_count_in;
         sample_count_ff <= sample_count_in;
      end
   end

   // stage one: table index and flags
   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s2_adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_idx_ff    <= phase_red[PHASE_FRAC_BITS-1 -: SINE_TABLE_BITS];
         s1_neg_ff    <= invert_in;
         s1_taken_ff  <= taken;
         s1_train_ff  <= training_in;
         s1_active_ff <= active;
      end
   end

   // sine lookup
   dbpskm_sine #(
      .SINE_TABLE_BITS (SINE_TABLE_BITS),
      .SAMPLE_BITS     (SAMPLE_BITS)
   ) u_sine (
      .idx    (s1_idx_ff),
      .negate (s1_neg_ff),
      .sample (sine_sample)
   );

   // output register
   assign rsp_valid_in = s2_adv ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_adv && s1_valid_ff) begin
         rsp_sample_ff <= sine_sample;
         rsp_taken_ff  <= s1_taken_ff;
         rsp_train_ff  <= s1_train_ff;
         rsp_active_ff <= s1_active_ff;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.sample       = rsp_sample_ff;
   assign rsp_ch.bit_taken    = rsp_taken_ff;
   assign rsp_ch.in_training  = rsp_train_ff;
   assign rsp_ch.frame_active = rsp_active_ff;

   // checks
   a_no_min_sample: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_sample_ff != {1'b1, (SAMPLE_BITS-1)'(0)})
      else $error("carrier sample reached the negative full scale code");

   a_taken_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_taken_ff |-> !rsp_train_ff && rsp_active_ff)
      else $error("bit taken while training or outside the frame");

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s2_adv |=> s1_valid_ff && $stable(s1_idx_ff))
      else $error("stage one request lost or changed under stall");

endmodule

### dv/tb_dbpsk_carrier_modulator_top.sv
// self-checking dbpsk modulator testbench: directed table, random frames, long preamble
`timescale 1ns / 1ps

module tb_dbpsk_carrier_modulator_top;
   import dbpskm_pkg::*;

   localparam int CYCLE_LIMIT   = 500000;
   localparam int AMPLITUDE     = 32767;
   localparam int QUARTER_STEPS = 256;
   localparam int RANDOM_PHASES = 11;
   localparam int PHASE_ITEMS   = 50;
   localparam int PREAMBLE_RUN  = 40;
   localparam int DIRECTED_ROWS = 31;

   // one carrier sample and its flags, as the result channel carries them
   typedef struct packed {
      logic signed [15:0] sample;
      logic               bit_taken;
      logic               in_training;
      logic               frame_active;
   } carrier_t;

   typedef enum logic {ROW_TICK, ROW_PROGRAM} row_kind_t;

   // a tick request, or a reprogramming of all four registers
   typedef struct packed {
      row_kind_t   kind;
      logic [31:0] step;
      logic [7:0]  cpb;
      logic [15:0] tlen;
      logic [31:0] flen;
      logic        start;
      logic        data;
      logic        typed;
      carrier_t    want;
   } stim_row_t;

   // directed table: typed results only where they are obvious
   localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
      // state after reset: phase zero, no frame
      '{ROW_TICK, 32'h0, 8'd0, 16'd0, 32'd0, 1'b0, 1'b0, 1'b1, '{16'sd0, 1'b0, 1'b1, 1'b0}},
      '{ROW_PROGRAM, 32'h3000_0000, 8'd4, 16'd8, 32'd0, 1'b0, 1'b0, 1'b0, '0},
      '{ROW_TICK, 32'h0, 8'd0, 16'd0, 32'd0, 1'b0, 1'b0, 1'b0, '0},
      // quarter-cycle steps hit the peaks and zero crossings
      '{ROW_PROGRAM, 32'h4000_0000, 8'd4, 16'd8, 32'd0, 1'b0, 1'b0, 1'b0, '0},
      '{ROW_TICK, 32'h0, 8'd0, 16'd0, 32'd0, 1'b0, 1'b0, 1'b1, '{16'sh7FFF, 1'b0, 1'b1, 1'b0}},
      '{ROW_TICK, 32'h0, 8'd0, 16'd0, 32'd0, 1'b0, 1'b1, 1'b1, '{16'sd0, 1'b0, 1'b1, 1'b0}},
      '{ROW_TICK, 32'h0, 8'd0, 16'd0, 32'd0, 1'b0, 1'b0, 1'b1, '{16'sh8001, 1'b0, 1'b1, 1'b0}},
      '{ROW_TICK, 32'h0, 8'd0, 16'd0, 32'd0, 1'b0, 1'b1, 1'b1, '{16'sd0, 1'b0, 1'b1, 1'b0}},
      // short preamble then data, with a restart mid frame
      '{ROW_PROGRAM, 32'h8000_0000, 8'd1, 16'd2, 32'd24, 1'b0, 1'b0, 1'b0, '0},
      '{ROW_TICK, 32'h0, 8'd0, 16'd0, 32'd0, 1'b1, 1'b1, 1'b0, '0},
      '{ROW_TICK, 32'h0, 8'd0, 16'd0, 32'd0, 1'b0, 1'b1, 1'b0, '0},
      '{ROW_TICK, 32'h0, 8'd0, 16'd0, 32'd0, 1'b0, 1'b0, 1'b0, '0},
      '{ROW_TICK, 32'h0, 8'd0, 16'd0, 32'd0, 1'b0, 1'b1, 1'b0, '0},
      '{ROW_TICK, 32'h0, 8'd0, 16'd0, 32'd0, 1'b0, 1'b1, 1'b0, '0},
      '{ROW_TICK, 32'h0, 8'd0, 16'd0, 32'd0, 1'b0, 1'b0, 1'b0, '0},
      '{ROW_TICK, 32'h0, 8'd0, 16'd0, 32'd0, 1'b0, 1'b1, 1'b0, '0},
      '{ROW_TICK, 32'h0, 8'd0, 16'd0, 32'd0, 1'b0, 1'b1, 1'b0, '0},
      '{ROW_TICK, 32'h0, 8'd0, 16'd0, 32'd0, 1'b1, 1'b1, 1'b0, '0},
      // largest step, zero bit period, no preamble, longest frame
      '{ROW_PROGRAM, 32'hFFFF_FFFF, 8'd0, 16'd0, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, '0},
      '{ROW_TICK, 32'h0, 8'd0, 16'd0, 32'd0, 1'b1, 1'b1, 1'b0, '0},
      '{ROW_TICK, 32'h0, 8'd0, 16'd0, 32'd0, 1'b0, 1'b1, 1'b0, '0},
      '{ROW_TICK, 32'h0, 8'd0, 16'd0, 32'd0, 1'b0, 1'b0, 1'b0, '0},
      '{ROW_TICK, 32'h0, 8'd0, 16'd0, 32'd0, 1'b0, 1'b1, 1'b0, '0},
      // zero step, widest bit period, empty frame
      '{ROW_PROGRAM, 32'h0, 8'd255, 16'hFFFF, 32'd0, 1'b0, 1'b0, 1'b0, '0},
      '{ROW_TICK, 32'h0, 8'd0, 16'd0, 32'd0, 1'b0, 1'b1, 1'b0, '0},
      '{ROW_TICK, 32'h0, 8'd0, 16'd0, 32'd0, 1'b1, 1'b1, 1'b0, '0},
      // bit period lowered under the phase, frame running out
      '{ROW_PROGRAM, 32'h1, 8'd1, 16'd1, 32'd3, 1'b0, 1'b0, 1'b0, '0},
      '{ROW_TICK, 32'h0, 8'd0, 16'd0, 32'd0, 1'b1, 1'b1, 1'b0, '0},
      '{ROW_TICK, 32'h0, 8'd0, 16'd0, 32'd0, 1'b0, 1'b1, 1'b0, '0},
      '{ROW_TICK, 32'h0, 8'd0, 16'd0, 32'd0, 1'b0, 1'b1, 1'b0, '0},
      '{ROW_TICK, 32'h0, 8'd0, 16'd0, 32'd0, 1'b0, 1'b1, 1'b0, '0}
   };

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      csr_wen;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   dbpskm_req_if req_ch ();
   dbpskm_rsp_if #(.SAMPLE_BITS(16)) rsp_ch ();

   dbpsk_carrier_modulator_top u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch)
   );

   // predictor copy of the registers
   logic [31:0] step_reg;
   logic [7:0]  cpb_reg;
   logic [15:0] train_len_reg;
   logic [31:0] frame_len_reg;

   // predictor copy of the modulator state
   logic [39:0] phase_acc;
   logic        inverted;
   logic        training_on;
   logic [15:0] preamble_cnt;
   logic [31:0] tick_cnt;

   int unsigned quarter_wave [0:QUARTER_STEPS];
   carrier_t    pending_samples [$];
   int          errors = 0;
   int          cycle_count = 0;
   logic        steady_flow = 1'b0;

   always #5 clock = ~clock;

   // quarter-wave sine in q30, taylor series to x^15, scaled to the amplitude
   function automatic void build_quarter_wave();
      longint unsigned x, x2, term, sum, v;
      for (int j = 0; j <= QUARTER_STEPS; j++) begin
         x = (HALF_PI_Q30 * longint'(j)) / QUARTER_STEPS;
         x2 = (x * x) >> 30;
         term = x;
         sum = x;
         for (int k = 1; k <= 7; k++) begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[k-1];
            if (k % 2 == 1) begin
               sum = (sum >= term) ? sum - term : 64'd0;
            end else begin
               sum = sum + term;
            end
         end
         v = (sum * AMPLITUDE + (64'd1 << 29)) >> 30;
         if (v > AMPLITUDE) begin
            v = AMPLITUDE;
         end
         quarter_wave[j] = int'(v);
      end
   endfunction

   // one sample tick: frame restart, bit boundary, sine lookup, phase advance
   function automatic carrier_t modulate(input logic start, input logic data);
      carrier_t    r;
      logic [39:0] limit;
      logic        active;
      logic [9:0]  idx;
      int          v;
      r = '0;
      limit = {cpb_reg, 32'd0};
      if (start) begin
         inverted = 1'b0;
         training_on = 1'b1;
         preamble_cnt = 16'd1;
         tick_cnt = 32'd1;
      end
      active = tick_cnt < frame_len_reg;
      if (phase_acc > limit) begin
         phase_acc = phase_acc - limit;
         if (active) begin
            if (preamble_cnt >= train_len_reg) begin
               training_on = 1'b0;
            end
            if (training_on) begin
               if (preamble_cnt != TRAIN_COUNT_MAX) begin
                  preamble_cnt = preamble_cnt + 16'd1;
               end
            end else begin
               r.bit_taken = 1'b1;
               if (data) begin
                  inverted = ~inverted;
               end
            end
         end
      end
      // quadrant fold of the quarter-wave table
      idx = phase_acc[31:22];
      v = idx[8] ? int'(quarter_wave[QUARTER_STEPS - idx[7:0]]) : int'(quarter_wave[idx[7:0]]);
      if (idx[9]) begin
         v = -v;
      end
      if (inverted) begin
         v = -v;
      end
      phase_acc = phase_acc + {8'd0, step_reg};
      if (active) begin
         tick_cnt = tick_cnt + 32'd1;
      end
      r.sample = v[15:0];
      r.in_training = training_on;
      r.frame_active = active;
      return r;
   endfunction

   // send one request, idling at random first, and record its expected sample
   task automatic issue_tick(input logic start, input logic data, input logic typed,
                             input carrier_t want);
      carrier_t predicted;
      while (!steady_flow && $urandom_range(99) < 35) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.start_frame <= start;
      req_ch.data_bit <= data;
      @(posedge clock);
      while (!req_ch.ready) begin
         @(posedge clock);
      end
      predicted = modulate(start, data);
      pending_samples.push_back(typed ? want : predicted);
   endtask

   // stop requests and let the pipeline empty
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (pending_samples.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   // write all four registers, one per cycle
   task automatic program_regs(input logic [31:0] step, input logic [7:0] cpb,
                               input logic [15:0] tlen, input logic [31:0] flen);
      csr_index_type idx;
      logic [31:0]   value;
      for (int i = 0; i < 4; i++) begin
         idx = csr_index_type'(i);
         case (idx)
            CSR_PHASE_STEP:     value = step;
            CSR_CYCLES_PER_BIT: value = {24'd0, cpb};
            CSR_TRAINING_BITS:  value = {16'd0, tlen};
            default:            value = flen;
         endcase
         csr_wen <= 1'b1;
         csr_index <= idx;
         csr_wdata <= value;
         @(posedge clock);
      end
      csr_wen <= 1'b0;
      step_reg = step;
      cpb_reg = cpb;
      train_len_reg = tlen;
      frame_len_reg = flen;
   endtask

   // result side: random stalls, compare with the oldest expected sample
   always @(posedge clock) begin : sample_check
      carrier_t want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (pending_samples.size() == 0) begin
               errors++;
               if (errors <= 10) begin
                  $display("unexpected sample %0d with no request outstanding", rsp_ch.sample);
               end
            end else begin
               want = pending_samples.pop_front();
               if (rsp_ch.sample !== want.sample || rsp_ch.bit_taken !== want.bit_taken ||
                   rsp_ch.in_training !== want.in_training ||
                   rsp_ch.frame_active !== want.frame_active) begin
                  errors++;
                  if (errors <= 10) begin
                     $display("mismatch exp sample=%0d taken=%b training=%b active=%b",
                              want.sample, want.bit_taken, want.in_training, want.frame_active);
                     $display("         got sample=%0d taken=%b training=%b active=%b",
                              rsp_ch.sample, rsp_ch.bit_taken, rsp_ch.in_training,
                              rsp_ch.frame_active);
                  end
               end
            end
         end
         rsp_ch.ready <= steady_flow || ($urandom_range(99) >= 35);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // stimulus
   initial begin : stimulus
      logic [31:0] step;
      logic [7:0]  cpb;
      logic [15:0] tlen;
      logic [31:0] flen;
      int          sent;
      int          frame_len;
      reset = 1'b1;
      csr_wen = 1'b0;
      csr_index = CSR_PHASE_STEP;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.start_frame = 1'b0;
      req_ch.data_bit = 1'b0;
      build_quarter_wave();
      step_reg = PHASE_STEP_RESET;
      cpb_reg = CYCLES_PER_BIT_RESET;
      train_len_reg = TRAINING_BITS_RESET;
      frame_len_reg = FRAME_SAMPLES_RESET;
      phase_acc = '0;
      inverted = 1'b0;
      training_on = 1'b1;
      preamble_cnt = 16'd1;
      tick_cnt = 32'd1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         if (DIRECTED[r].kind == ROW_PROGRAM) begin
            settle();
            program_regs(DIRECTED[r].step, DIRECTED[r].cpb, DIRECTED[r].tlen, DIRECTED[r].flen);
         end else begin
            issue_tick(DIRECTED[r].start, DIRECTED[r].data, DIRECTED[r].typed, DIRECTED[r].want);
         end
      end

      // random frames under random settings, extremes now and then
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case ($urandom_range(9))
            0:       step = 32'd0;
            1:       step = 32'hFFFF_FFFF;
            default: step = $urandom_range(32'hC000_0000, 32'h2000_0000);
         endcase
         case ($urandom_range(9))
            0:       cpb = 8'd0;
            1:       cpb = 8'd255;
            default: cpb = 8'($urandom_range(3, 1));
         endcase
         case ($urandom_range(9))
            0:       tlen = 16'hFFFF;
            default: tlen = 16'($urandom_range(5));
         endcase
         case ($urandom_range(9))
            0:       flen = 32'd0;
            1:       flen = 32'hFFFF_FFFF;
            default: flen = $urandom_range(60, 10);
         endcase
         settle();
         program_regs(step, cpb, tlen, flen);
         steady_flow = (ph == 4);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            frame_len = $urandom_range(60, 6);
            for (int k = 0; k < frame_len && sent < PHASE_ITEMS; k++) begin
               issue_tick(k == 0 || $urandom_range(99) < 2, $urandom_range(1) == 1, 1'b0, '0);
               sent++;
            end
         end
      end

      // long preamble: every tick a boundary while training counts up
      settle();
      program_regs($urandom | 32'h0100_0001, 8'd0, 16'hFFFF, 32'hFFFF_FFFF);
      steady_flow = 1'b1;
      for (int k = 0; k < PREAMBLE_RUN; k++) begin
         issue_tick(k == 0, $urandom_range(1) == 1, 1'b0, '0);
      end

      settle();
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

### files.f
rtl/dbpskm_pkg.sv
rtl/dbpskm_if.sv
rtl/dbpskm_sine.sv
rtl/dbpsk_carrier_modulator_top.sv
dv/tb_dbpsk_carrier_modulator_top.sv
